// File: rtl/core/swps_pkg.sv
// ----------------------------------------------------------------------------
// swps_pkg
// Shared types and constants of the sliding window pattern scorer.
// ----------------------------------------------------------------------------
package swps_pkg;

  localparam int PAT_MAX  = 256;
  localparam int CNT_W    = $clog2(PAT_MAX + 1);
  localparam int SYM_W    = 8;
  localparam int POS_W    = 32;
  localparam int SCORE_W  = 9;
  localparam int SCORE_MAX = 511;
  localparam int GRP      = 16;
  localparam int NGRP     = (PAT_MAX + GRP - 1) / GRP;
  localparam int GRP_W    = $clog2(GRP + 1);
  localparam int CFG_IDX_W = 1;

  localparam logic CMD_PATTERN = 1'b0;
  localparam logic CMD_BASE    = 1'b1;

  localparam logic [SYM_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [SYM_W-1:0] CH_TAB     = 8'h09;
  localparam logic [SYM_W-1:0] CH_NEWLINE = 8'h0A;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCORE_MODE = 1'b0,
    CFG_DROP_WS    = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GROUP,
    ST_TOTAL
  } state_t;

  typedef struct packed {
    logic             cmd;
    logic [SYM_W-1:0] symbol;
    logic             restart;
  } in_req_t;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [SCORE_W-1:0] score;
  } out_rsp_t;

  typedef struct packed {
    logic pat_shift;
    logic pat_clr;
    logic win_shift;
  } cell_ctl_t;

  function automatic logic is_blank(input logic [SYM_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
  endfunction

endpackage

// File: rtl/core/swps_cell.sv
// ----------------------------------------------------------------------------
// swps_cell
// One position of the pattern and window shift chains with its compare.
// ----------------------------------------------------------------------------
module swps_cell
  import swps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic [SYM_W-1:0] pat_in,
  input  logic             pv_in,
  input  logic [SYM_W-1:0] win_in,
  output logic [SYM_W-1:0] pat_out,
  output logic             pv_out,
  output logic [SYM_W-1:0] win_out,
  output logic             match
);

  logic [SYM_W-1:0] pat_r;
  logic             pv_r;
  logic [SYM_W-1:0] win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (ctl.pat_shift) begin
      pv_r <= pv_in;
    end else if (ctl.pat_clr) begin
      pv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pat_shift) begin
      pat_r <= pat_in;
    end
    if (ctl.win_shift) begin
      win_r <= win_in;
    end
  end

  assign pat_out = pat_r;
  assign pv_out  = pv_r;
  assign win_out = win_r;
  assign match   = pv_r && (win_r == pat_r);

endmodule

// File: rtl/core/swps_tally.sv
// ----------------------------------------------------------------------------
// swps_tally
// Two-level count of matching cells: registered group counts, then a sum.
// ----------------------------------------------------------------------------
module swps_tally
  import swps_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic [PAT_MAX-1:0] match,
  output logic [CNT_W-1:0]   total
);

  logic [NGRP*GRP-1:0] match_pad;
  logic [GRP_W-1:0]    grp_cnt_r [NGRP];

  always_comb begin
    match_pad              = '0;
    match_pad[PAT_MAX-1:0] = match;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_cnt_r[g] <= GRP_W'($countones(match_pad[g*GRP +: GRP]));
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NGRP; g++) begin
      total = total + CNT_W'(grp_cnt_r[g]);
    end
  end

endmodule

// File: rtl/core/sliding_window_pattern_scorer.sv
// ----------------------------------------------------------------------------
// sliding_window_pattern_scorer
// Scores every window of a streamed base sequence against a stored pattern.
// ----------------------------------------------------------------------------
// Input requests carry cmd, symbol and restart. A pattern request (cmd 0)
// appends a character to the pattern (restart starts a new one) and resets
// the base window. A base request (cmd 1) shifts a character into the
// window (restart starts a new sequence). Once the window holds as many
// characters as the pattern, each kept base character gives one result:
// the window start position and, per score_mode, a whole-match flag or the
// count of equal positions. Space, tab and newline are dropped when
// drop_whitespace is set. Configuration writes use cfg_valid/cfg_ready and
// are taken only while the block is idle.
// Requests that give no result leave the block idle. A request that gives a
// result takes three steps: the cell chain shifts on acceptance, group
// counts register in ST_GROUP, and the summed score loads the output
// register in ST_TOTAL. The output register lets the next request in while
// a result waits; a stalled receiver holds the block in its final step.
// Reset clears pattern length, window fill and position; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module sliding_window_pattern_scorer
  import swps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_rsp_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data
);

  state_t           state_r, state_nxt;
  logic             score_mode_r, drop_ws_r;
  logic [CNT_W-1:0] pc_r, pc_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] res_pos_r, res_pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_rsp_t         out_data_r, out_data_nxt;
  cell_ctl_t        ctl;
  logic             accept, drop, load_grp;
  logic [CNT_W-1:0] pc_eff, fill_eff, fill_inc;
  logic [POS_W-1:0] pos_eff;
  logic [CNT_W-1:0] total;
  logic [SCORE_W-1:0] score_val;

  logic [SYM_W-1:0]   pat_q [PAT_MAX];
  logic               pv_q  [PAT_MAX];
  logic [SYM_W-1:0]   win_q [PAT_MAX];
  logic [PAT_MAX-1:0] match;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE);
  assign drop      = drop_ws_r && is_blank(in_data.symbol);
  assign load_grp  = (state_r == ST_GROUP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_mode_r <= 1'b0;
      drop_ws_r    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SCORE_MODE: score_mode_r <= cfg_data;
        CFG_DROP_WS:    drop_ws_r    <= cfg_data;
        default:        ;
      endcase
    end
  end

  for (genvar j = 0; j < PAT_MAX; j++) begin : g_cell
    logic [SYM_W-1:0] pat_src, win_src;
    logic             pv_src;
    if (j == PAT_MAX - 1) begin : g_top
      assign pat_src = in_data.symbol;
      assign win_src = in_data.symbol;
      assign pv_src  = 1'b1;
    end else begin : g_mid
      assign pat_src = pat_q[j+1];
      assign win_src = win_q[j+1];
      assign pv_src  = pv_q[j+1] && !ctl.pat_clr;
    end
    swps_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .pat_in  (pat_src),
      .pv_in   (pv_src),
      .win_in  (win_src),
      .pat_out (pat_q[j]),
      .pv_out  (pv_q[j]),
      .win_out (win_q[j]),
      .match   (match[j])
    );
  end

  swps_tally u_tally (
    .clk   (clk),
    .load  (load_grp),
    .match (match),
    .total (total)
  );

  always_comb begin
    if (score_mode_r) begin
      score_val = (total > CNT_W'(SCORE_MAX)) ? SCORE_W'(SCORE_MAX) : SCORE_W'(total);
    end else begin
      score_val = (total == pc_r) ? SCORE_W'(1) : SCORE_W'(0);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    res_pos_nxt   = res_pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    pc_eff        = in_data.restart ? '0 : pc_r;
    fill_eff      = in_data.restart ? '0 : fill_r;
    pos_eff       = in_data.restart ? '0 : pos_r;
    fill_inc      = (fill_eff < pc_r) ? fill_eff + CNT_W'(1) : fill_eff;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.cmd == CMD_PATTERN) begin
            fill_nxt    = '0;
            pos_nxt     = '0;
            pc_nxt      = pc_eff;
            ctl.pat_clr = in_data.restart;
            if (!drop && (pc_eff < CNT_W'(PAT_MAX))) begin
              ctl.pat_shift = 1'b1;
              pc_nxt        = pc_eff + CNT_W'(1);
            end
          end else begin
            fill_nxt = fill_eff;
            pos_nxt  = pos_eff;
            if (!drop) begin
              ctl.win_shift = 1'b1;
              fill_nxt      = fill_inc;
              if (fill_inc >= pc_r) begin
                res_pos_nxt = pos_eff;
                pos_nxt     = pos_eff + POS_W'(1);
                state_nxt   = ST_GROUP;
              end
            end
          end
        end
      end
      ST_GROUP: begin
        state_nxt = ST_TOTAL;
      end
      ST_TOTAL: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.position = res_pos_r;
          out_data_nxt.score    = score_val;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      fill_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      fill_r      <= fill_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_pos_r  <= res_pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/swps_checker.sv
// ----------------------------------------------------------------------------
// swps_checker
// Port-level checks of the sliding window pattern scorer.
// ----------------------------------------------------------------------------
module swps_checker
  import swps_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input out_rsp_t             out_data,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic                 cfg_data
);

  logic score_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready && (cfg_index == CFG_SCORE_MODE)) begin
      score_mode_r <= cfg_data;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("reset left a result or busy state");

  a_exact_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !score_mode_r) |-> (out_data.score <= SCORE_W'(1)))
    else $error("exact mode score above one");

endmodule

bind sliding_window_pattern_scorer swps_checker u_checker (.*);
